// ===== rtl/core/ile_pkg.sv =====
// ile_pkg: request and result item types and operation codes for the indexed list engine
// no dependencies
package ile_pkg;

    localparam logic [2:0] OP_GET  = 3'd0;
    localparam logic [2:0] OP_HEAD = 3'd1;
    localparam logic [2:0] OP_TAIL = 3'd2;
    localparam logic [2:0] OP_IDX  = 3'd3;
    localparam logic [2:0] OP_DEL  = 3'd4;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [7:0]        position;
        logic signed [DATA_W-1:0] value;
    } t_ile_in;

    typedef struct packed {
        logic                     done_res;
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         length;
    } t_ile_out;

    typedef struct packed {
        logic ins;
        logic del;
        logic rd;
    } t_cell_op;

endpackage

// ===== rtl/core/ile_cell.sv =====
// ile_cell: one storage cell of the list, shifts with its neighbors on insert and delete
// depends on ile_pkg
module ile_cell import ile_pkg::*; #(
    parameter int IDX  = 0,
    parameter int AT_W = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_op          i_op,
    input  logic [AT_W-1:0]   i_at,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_rd_data
);

    localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              hit;
    logic              behind;

    assign hit    = (i_at == MY_IDX);
    assign behind = (MY_IDX > i_at);

    always_comb begin
        n_data = r_data;
        if (i_op.ins) begin
            if (hit) begin
                n_data = i_value;
            end else if (behind) begin
                n_data = i_left;
            end
        end else if (i_op.del) begin
            if (hit || behind) begin
                n_data = i_right;
            end
        end
    end

    // payload only, reset kept for the control side of the chain
    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            r_data <= n_data;
        end
    end

    assign o_data    = r_data;
    assign o_rd_data = (i_op.rd && hit) ? r_data : '0;

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// indexed_list_engine: top level, request decode, length counter, result register
// depends on ile_pkg and ile_cell
//
// An ordered list of up to CAPACITY signed 32-bit words held in a row of cells. Each request
// item reads, inserts (head, tail or before an index) or deletes at an index and returns one
// result item: done flag, value read (-1 unless a successful get) and the new length. One
// request is taken per cycle unless the output stalls; every cell from the position on takes
// a neighbor's or the new word in the same cycle on insert or delete, and a get selects one
// cell's word across the row. The result register lets a new item in while the last
// result is being taken. Words beyond the current length are never read and need no clearing.
module indexed_list_engine import ile_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ile_in  i_in_item,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_ile_out o_out_item
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CW > LEN_W) ? CW : LEN_W) + 1;

    logic [CW-1:0]     r_count;
    logic              r_out_valid;
    t_ile_out          r_out_item;

    logic              accept;
    logic              neg;
    logic              zero_pos;
    logic [CMP_W-1:0]  upos;
    logic [CMP_W-1:0]  cnt;
    logic [CMP_W-1:0]  at_ext;
    logic [CMP_W-1:0]  n_cnt_ext;
    logic              in_range;
    logic              is_ins;
    logic              get_ok;
    logic              ins_ok;
    logic              del_ok;
    t_cell_op          cell_op;
    logic [CW-1:0]     at;
    logic [DATA_W-1:0] rd_word;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];

    assign accept   = i_in_valid && o_in_ready;
    assign neg      = i_in_item.position[7];
    assign zero_pos = (i_in_item.position == '0);
    assign upos     = CMP_W'(i_in_item.position[6:0]);
    assign cnt      = CMP_W'(r_count);
    assign in_range = !neg && (upos < cnt);
    assign is_ins   = (i_in_item.op == OP_HEAD) || (i_in_item.op == OP_TAIL)
                      || (i_in_item.op == OP_IDX);

    always_comb begin
        case (i_in_item.op)
            OP_HEAD: at_ext = '0;
            OP_TAIL: at_ext = cnt;
            OP_IDX:  at_ext = (neg || zero_pos) ? '0 : upos;
            default: at_ext = upos;
        endcase
    end

    assign at     = at_ext[CW-1:0];
    assign get_ok = (i_in_item.op == OP_GET) && in_range;
    assign del_ok = (i_in_item.op == OP_DEL) && in_range;
    assign ins_ok = is_ins && (cnt < CMP_W'(CAPACITY)) && (at_ext <= cnt);

    assign cell_op.ins = accept && ins_ok;
    assign cell_op.del = accept && del_ok;
    assign cell_op.rd  = get_ok;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = i_in_item.value;
        end else begin : g_mid
            assign left_w = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_w = cell_data[g];
        end else begin : g_inner
            assign right_w = cell_data[g+1];
        end
        ile_cell #(
            .IDX  (g),
            .AT_W (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_op      (cell_op),
            .i_at      (at),
            .i_value   (i_in_item.value),
            .i_left    (left_w),
            .i_right   (right_w),
            .o_data    (cell_data[g]),
            .o_rd_data (cell_rd[g])
        );
    end

    always_comb begin
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_word = rd_word | cell_rd[k];
        end
    end

    always_comb begin
        n_cnt_ext = cnt;
        if (ins_ok) begin
            n_cnt_ext = cnt + CMP_W'(1);
        end else if (del_ok) begin
            n_cnt_ext = cnt - CMP_W'(1);
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_cnt_ext[CW-1:0];
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item.done_res   <= get_ok || ins_ok || del_ok;
            r_out_item.read_value <= get_ok ? rd_word : '1;
            r_out_item.length     <= n_cnt_ext[LEN_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ins_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_refused_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !ins_ok && !del_ok) |=> $stable(r_count))
        else $error("refused item changed the length");

    a_read_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.done_res) |-> (o_out_item.read_value == '1))
        else $error("refused item carries a read value");

endmodule
